@@ rtl/cbwf_pkg.sv @@
// Shared types and constants for the complex biquad wall filter.
package cbwf_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 15;
  // Q2.x coefficients: sign bit, two integer bits, then the fraction.
  localparam int COEF_WIDTH     = COEF_FRAC_BITS + 3;
  localparam int NUM_COEFS      = 5;
  localparam int CFG_IDX_WIDTH  = $clog2(NUM_COEFS);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_B0 = 0,
    REG_B1 = 1,
    REG_B2 = 2,
    REG_A1 = 3,
    REG_A2 = 4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
    logic                           burst_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered_re;
    logic signed [SAMPLE_WIDTH-1:0] filtered_im;
    logic                           clipped;
  } out_item_t;

endpackage

@@ rtl/complex_biquad_wall_filter.sv @@
// Complex direct form I biquad wall filter: coefficient registers, histories and datapath.
//
// Filters complex I/Q samples with y = b0*x0 + b1*x1 + b2*x2 - a1*y1 - a2*y2, using the
// same Q2.15 coefficients on both parts, rounding to nearest (ties up) and saturating to
// 16 bits; clipped flags a saturated part. A beat with burst_start set is filtered as if
// both histories were zero. It takes one sample every cycle unless the output is stalled;
// each sample passes through the input register and then the result register. The
// single pass between them is set by the output feedback: ten 18x16 multipliers, the
// five-term sum, rounding and saturation sit between the input register and the result
// register, and the saturated output returns to the history in the same cycle.
// Coefficients are written through the cfg port, which is always ready; writes to an
// index above four are dropped.
module complex_biquad_wall_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cbwf_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cbwf_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cbwf_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [cbwf_pkg::COEF_WIDTH-1:0]     cfg_data_i
);

  localparam int SW        = cbwf_pkg::SAMPLE_WIDTH;
  localparam int CW        = cbwf_pkg::COEF_WIDTH;
  localparam int FB        = cbwf_pkg::COEF_FRAC_BITS;
  localparam int PROD_W    = CW + SW;
  localparam int ACC_W     = PROD_W + 3;
  localparam int RND_W     = ACC_W - FB;

  typedef struct packed {
    logic signed [SW-1:0] x1;
    logic signed [SW-1:0] x2;
    logic signed [SW-1:0] y1;
    logic signed [SW-1:0] y2;
  } hist_t;

  typedef struct packed {
    logic signed [SW-1:0] y;
    logic                 clip;
  } part_res_t;

  logic signed [CW-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;

  cbwf_pkg::in_item_t  in_q;
  logic                in_valid_q;
  cbwf_pkg::out_item_t out_q;
  logic                out_valid_q;
  hist_t               hist_re_q, hist_im_q;
  hist_t               eff_re, eff_im;
  part_res_t           res_re, res_im;
  logic                advance;

  // One part of the filter: exact sum, round half up, saturate.
  function automatic part_res_t filter_part(
    input logic signed [SW-1:0] x0,
    input hist_t                h,
    input logic signed [CW-1:0] b0,
    input logic signed [CW-1:0] b1,
    input logic signed [CW-1:0] b2,
    input logic signed [CW-1:0] a1,
    input logic signed [CW-1:0] a2
  );
    logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]         rnd_sum;
    logic [RND_W-1:0]         rnd;
    part_res_t                r;
    p0 = b0 * x0;
    p1 = b1 * h.x1;
    p2 = b2 * h.x2;
    p3 = a1 * h.y1;
    p4 = a2 * h.y2;
    acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4);
    rnd_sum = acc + (ACC_W'(1) << (FB - 1));
    rnd = rnd_sum[ACC_W-1:FB];
    // The value fits when every bit above the sample's sign bit matches it.
    if (rnd[RND_W-1:SW-1] == '0 || rnd[RND_W-1:SW-1] == '1) begin
      r.y    = rnd[SW-1:0];
      r.clip = 1'b0;
    end else begin
      r.y    = rnd[RND_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      r.clip = 1'b1;
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= '0;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cbwf_pkg::cfg_reg_e'(cfg_index_i))
        cbwf_pkg::REG_B0: coef_b0_q <= cfg_data_i;
        cbwf_pkg::REG_B1: coef_b1_q <= cfg_data_i;
        cbwf_pkg::REG_B2: coef_b2_q <= cfg_data_i;
        cbwf_pkg::REG_A1: coef_a1_q <= cfg_data_i;
        cbwf_pkg::REG_A2: coef_a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The held sample moves on when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  assign eff_re = in_q.burst_start ? '0 : hist_re_q;
  assign eff_im = in_q.burst_start ? '0 : hist_im_q;

  assign res_re = filter_part(in_q.sample_re, eff_re, coef_b0_q, coef_b1_q, coef_b2_q,
                              coef_a1_q, coef_a2_q);
  assign res_im = filter_part(in_q.sample_im, eff_im, coef_b0_q, coef_b1_q, coef_b2_q,
                              coef_a1_q, coef_a2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_re_q   <= '0;
      hist_im_q   <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        hist_re_q   <= '{x1: in_q.sample_re, x2: eff_re.x1, y1: res_re.y, y2: eff_re.y1};
        hist_im_q   <= '{x1: in_q.sample_im, x2: eff_im.x1, y1: res_im.y, y2: eff_im.y1};
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q.filtered_re <= res_re.y;
      out_q.filtered_im <= res_im.y;
      out_q.clipped     <= res_re.clip | res_im.clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/cbwf_checker.sv @@
// Port-level assertions for the complex biquad wall filter and their bind.
module cbwf_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_stall_o,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  cbwf_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_o
);

  localparam int SW = cbwf_pkg::SAMPLE_WIDTH;
  localparam logic [SW-1:0] MAX_S = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] MIN_S = {1'b1, {(SW-1){1'b0}}};

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The input is held back only when a full result register is stalled downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  // A clipped result has at least one part sitting on a rail.
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.filtered_re == MAX_S || out_data_o.filtered_re == MIN_S ||
      out_data_o.filtered_im == MAX_S || out_data_o.filtered_im == MIN_S)
    else $error("clipped set on an unsaturated result");

  // The configuration port never pushes back.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind complex_biquad_wall_filter cbwf_checker u_cbwf_checker (.*);
